### rtl/byte_ring_buffer_defines.svh
// ----------------------------------------------------------------------------
// byte_ring_buffer_defines.svh
// Assertion macros for the byte ring buffer; empty bodies when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_DEFINES_SVH
`define BYTE_RING_BUFFER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte_ring_buffer assertion failed");
// next-cycle implication
`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte_ring_buffer assertion failed");
`else
`define BRB_ASSERT_NOW(label, clk, rst, ante, cons)
`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Command codes and request / result types of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  localparam int unsigned CNT_W  = 6;
  localparam int unsigned BYTE_W = 8;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] data_byte;
    logic              run_end;
    logic [CNT_W-1:0]  count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  done_count;
    logic              final_item;
    logic [CNT_W-1:0]  fill_level;
    logic              is_full;
    logic              is_empty;
  } out_item_t;

endpackage

### rtl/brb_mem.sv
// ----------------------------------------------------------------------------
// brb_mem
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brb_mem
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

### rtl/brb_wrap_add.sv
// ----------------------------------------------------------------------------
// brb_wrap_add
// Shared pointer adder: (a + b) mod DEPTH for a, b below DEPTH.
// ----------------------------------------------------------------------------
module brb_wrap_add
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [AW-1:0] sum
);

  logic [AW:0] raw;

  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    if (raw >= (AW+1)'(DEPTH)) begin
      raw = raw - (AW+1)'(DEPTH);
    end
    sum = raw[AW-1:0];
  end

endmodule

### rtl/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte ring buffer of DEPTH slots with one slot kept empty.
// ----------------------------------------------------------------------------
// Usage:
//   A request (push, pop, read or clear) is taken at a clock edge with start
//   high and busy low. Each result sits on the result port for one cycle,
//   marked by strobe; the receiver always takes it and cannot stall.
//   Push, pop and clear leave busy low: a result (if any) shows in the
//   cycle after the request, and a new request may follow at once.
//   A push not marked run_end gives no result.
//   A successful read of N bytes holds busy while it reads the store, one
//   memory read a cycle; results stream out one per cycle, the last with
//   final_item set. The next request is taken once busy is low again. The
//   byte store's registered single read port and the shared pointer adder
//   set this rate.
//   A refused read gives one result, in the cycle after the request.
//   Reset empties the buffer and clears the run count; store contents are
//   left as they were and are only reachable after being pushed again.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_defines.svh"

module byte_ring_buffer
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  request,
  output out_item_t result,
  output logic      strobe
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [AW-1:0] LVL_MAX = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] RUN_MAX = '1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t            state;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     level;
  logic [CNT_W-1:0]  run_stored;
  logic [AW-1:0]     rd_addr;
  logic [CNT_W-1:0]  rd_remain;
  logic [CNT_W-1:0]  rd_count;
  out_item_t         res;
  logic              res_mem;

  logic              accept;
  logic              has_room;
  logic [CW-1:0]     cnt_ext;
  logic [CW-1:0]     lvl_ext;
  logic [AW-1:0]     pop_n;
  logic              read_ok;
  logic [CNT_W-1:0]  run_next;
  logic [AW-1:0]     lvl_after;
  logic [AW-1:0]     add_a;
  logic [AW-1:0]     add_b;
  logic [AW-1:0]     add_sum;
  logic              mem_we;
  logic              mem_re;
  logic [BYTE_W-1:0] rdata;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign has_room = (level != LVL_MAX);
  assign cnt_ext  = CW'(request.count);
  assign lvl_ext  = CW'(level);
  assign pop_n    = (cnt_ext <= lvl_ext) ? AW'(cnt_ext) : level;
  assign read_ok  = (request.count != '0) && (cnt_ext <= lvl_ext);
  assign run_next = (has_room && run_stored != RUN_MAX) ? run_stored + 1'b1 : run_stored;
  assign mem_we   = accept && (request.cmd == CMD_PUSH) && has_room;
  assign mem_re   = (state == ST_READ);

  always_comb begin
    case (request.cmd)
      CMD_PUSH:  lvl_after = has_room ? level + 1'b1 : level;
      CMD_POP:   lvl_after = level - pop_n;
      CMD_READ:  lvl_after = level;
      CMD_CLEAR: lvl_after = '0;
      default:   lvl_after = level;
    endcase
  end

  // one adder serves tail advance, head advance on pop and the read walk
  always_comb begin
    add_a = tail;
    add_b = AW'(1);
    case (state)
      ST_READ: begin
        add_a = rd_addr;
      end
      default: begin
        if (request.cmd == CMD_POP) begin
          add_a = head;
          add_b = pop_n;
        end
      end
    endcase
  end

  brb_wrap_add #(.DEPTH(DEPTH), .AW(AW)) u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  brb_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail),
    .wdata (request.data_byte),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      level      <= '0;
      run_stored <= '0;
      rd_remain  <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res.out_byte   <= '0;
            res.final_item <= 1'b1;
            res.fill_level <= CNT_W'(lvl_after);
            res.is_full    <= (lvl_after == LVL_MAX);
            res.is_empty   <= (lvl_after == '0);
            res_mem        <= 1'b0;
            level          <= lvl_after;
            case (request.cmd)
              CMD_PUSH: begin
                if (has_room) begin
                  tail <= add_sum;
                end
                if (request.run_end) begin
                  strobe         <= 1'b1;
                  res.done_count <= run_next;
                  run_stored     <= '0;
                end else begin
                  run_stored <= run_next;
                end
              end
              CMD_POP: begin
                head           <= add_sum;
                strobe         <= 1'b1;
                res.done_count <= CNT_W'(pop_n);
              end
              CMD_READ: begin
                if (read_ok) begin
                  state     <= ST_READ;
                  rd_addr   <= head;
                  rd_remain <= request.count;
                  rd_count  <= request.count;
                end else begin
                  strobe         <= 1'b1;
                  res.done_count <= '0;
                end
              end
              CMD_CLEAR: begin
                head           <= tail;
                strobe         <= 1'b1;
                res.done_count <= '0;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_READ: begin
          // byte arrives from the store together with this result
          rd_addr        <= add_sum;
          rd_remain      <= rd_remain - 1'b1;
          strobe         <= 1'b1;
          res_mem        <= 1'b1;
          res.out_byte   <= '0;
          res.done_count <= rd_count;
          res.final_item <= (rd_remain == CNT_W'(1));
          res.fill_level <= CNT_W'(level);
          res.is_full    <= (level == LVL_MAX);
          res.is_empty   <= (level == '0);
          if (rd_remain == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result = res;
    if (res_mem) begin
      result.out_byte = rdata;
    end
  end

  `BRB_ASSERT_NOW(a_level_max, clk, rst, 1'b1, level <= LVL_MAX)
  `BRB_ASSERT_NOW(a_empty_ptrs, clk, rst, 1'b1, (level == '0) == (head == tail))
  `BRB_ASSERT_NOW(a_read_stream, clk, rst, strobe && !result.final_item, busy)
  `BRB_ASSERT_NEXT(a_push_level, clk, rst,
    accept && request.cmd == CMD_PUSH && has_room, level == $past(level) + 1'b1)

endmodule
